/* rtl/core/lsf_pkg.sv */
// ----------------------------------------------------------------------------
// lsf_pkg
// Shared types, constants and helpers for the line substring filter.
// ----------------------------------------------------------------------------
package lsf_pkg;

   localparam int          PAT_BYTES    = 16;
   localparam logic [7:0]  NEWLINE_BYTE = 8'd10;

   localparam int          CSR_IDX_W    = 3;
   localparam int          CSR_DATA_W   = 64;

   localparam logic [CSR_IDX_W-1:0] CSR_PAT_LOW  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PAT_HIGH = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PAT_LEN  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FOLD     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_INVERT   = 3'd4;

   typedef logic [PAT_BYTES-1:0][7:0] pattern_type;

   typedef struct packed {
      pattern_type pattern;
      logic [4:0]  used_len;
      logic        fold_case;
      logic        invert_selection;
   } cfg_type;

   typedef struct packed {
      logic shift;
      logic clear;
   } cell_ctl_type;

   // ASCII upper to lower case when enabled
   function automatic logic [7:0] fold_byte(input logic [7:0] b, input logic en);
      logic [7:0] r;
      r = b;
      if (en && b >= 8'd65 && b <= 8'd90) begin
         r = b + 8'd32;
      end
      return r;
   endfunction

endpackage

/* rtl/core/lsf_if.sv */
// ----------------------------------------------------------------------------
// lsf_if
// Request and response channel interfaces of the line substring filter.
// ----------------------------------------------------------------------------
interface lsf_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_stream;

   modport source (output valid, output data_byte, output end_of_stream, input ready);
   modport sink   (input valid, input data_byte, input end_of_stream, output ready);
endinterface

interface lsf_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] line_number;
   logic        at_stream_end;

   modport source (output valid, output line_number, output at_stream_end, input ready);
   modport sink   (input valid, input line_number, input at_stream_end, output ready);
endinterface

/* rtl/core/lsf_csr.sv */
// ----------------------------------------------------------------------------
// lsf_csr
// Configuration registers; presents the clamped pattern length.
// ----------------------------------------------------------------------------
module lsf_csr
   import lsf_pkg::*;
#(
   parameter int MAX_PATTERN = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data,
   output cfg_type               cfg
);

   localparam int LEN_LIMIT = (MAX_PATTERN < PAT_BYTES) ? MAX_PATTERN : PAT_BYTES;

   logic [63:0] pat_low_ff;
   logic [63:0] pat_high_ff;
   logic [4:0]  pat_len_ff;
   logic        fold_ff;
   logic        invert_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_low_ff  <= '0;
         pat_high_ff <= '0;
         pat_len_ff  <= '0;
         fold_ff     <= 1'b0;
         invert_ff   <= 1'b0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_PAT_LOW:  pat_low_ff  <= csr_write_data;
            CSR_PAT_HIGH: pat_high_ff <= csr_write_data;
            CSR_PAT_LEN:  pat_len_ff  <= csr_write_data[4:0];
            CSR_FOLD:     fold_ff     <= csr_write_data[0];
            CSR_INVERT:   invert_ff   <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      cfg.pattern          = pattern_type'({pat_high_ff, pat_low_ff});
      cfg.used_len         = (pat_len_ff > 5'(LEN_LIMIT)) ? 5'(LEN_LIMIT) : pat_len_ff;
      cfg.fold_case        = fold_ff;
      cfg.invert_selection = invert_ff;
   end

endmodule

/* rtl/core/lsf_cell.sv */
// ----------------------------------------------------------------------------
// lsf_cell
// One window slot: holds a line byte and its valid bit, passes both to the
// next slot on every shift, and compares its incoming byte to its pattern byte.
// ----------------------------------------------------------------------------
module lsf_cell
   import lsf_pkg::*;
#(
   parameter int SLOT = 0
) (
   input  logic         clock,
   input  logic         reset,
   input  cell_ctl_type ctl,
   input  cfg_type      cfg,
   input  logic [7:0]   byte_in,
   input  logic         valid_in,
   output logic [7:0]   byte_out,
   output logic         valid_out,
   output logic         match
);

   logic [7:0] byte_ff;
   logic       valid_ff;
   logic       active;
   logic [4:0] pat_idx;
   logic [7:0] pat_byte;

   always_ff @(posedge clock) begin
      if (ctl.shift) begin
         byte_ff <= byte_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || ctl.clear) begin
         valid_ff <= 1'b0;
      end else if (ctl.shift) begin
         valid_ff <= valid_in;
      end
   end

   // slot k lines up with pattern byte used_len-1-k
   always_comb begin
      active   = (32'(cfg.used_len) > SLOT);
      pat_idx  = cfg.used_len - 5'(SLOT) - 5'd1;
      pat_byte = cfg.pattern[pat_idx[3:0]];
      match    = !active ||
                 (valid_in && (fold_byte(byte_in, cfg.fold_case) ==
                               fold_byte(pat_byte, cfg.fold_case)));
   end

   assign byte_out  = byte_ff;
   assign valid_out = valid_ff;

endmodule

/* rtl/core/line_substring_filter.sv */
// ----------------------------------------------------------------------------
// line_substring_filter
// Splits a byte stream into lines and reports the numbers of lines that do
// (or, inverted, do not) contain a fixed pattern of up to 16 bytes.
//
//   channel  dir  transfer payload
//   req_chan in   data_byte[7:0], end_of_stream
//   rsp_chan out  line_number[31:0], at_stream_end
//   csr_*    in   write enable, index[2:0], write data[63:0]
//
// One byte per cycle; the match decision for a byte is made in its accept
// cycle across the slot chain and the result lands in the output register.
// A line's result appears the cycle after its newline or end-of-stream byte.
// The request side stalls only while a result waits unclaimed on rsp_chan.
// Synchronous reset clears line state; the line counter restarts at one.
// ----------------------------------------------------------------------------
module line_substring_filter
   import lsf_pkg::*;
#(
   parameter int MAX_PATTERN = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   lsf_req_if.sink               req_chan,
   lsf_rsp_if.source             rsp_chan,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data
);

   cfg_type      cfg;
   cell_ctl_type ctl;

   logic [MAX_PATTERN:0][7:0] chain_byte;
   logic [MAX_PATTERN:0]      chain_valid;
   logic [MAX_PATTERN-1:0]    slot_match;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_line_ff, rsp_line_in;
   logic        rsp_eos_ff, rsp_eos_in;
   logic        line_hit_ff, line_hit_in;
   logic [31:0] line_counter_ff, line_counter_in;

   logic accept, is_newline, line_ends, hit_now, selected, emit;

   lsf_csr #(.MAX_PATTERN(MAX_PATTERN)) u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   assign chain_byte[0]  = req_chan.data_byte;
   assign chain_valid[0] = 1'b1;

   for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
      lsf_cell #(.SLOT(k)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctl       (ctl),
         .cfg       (cfg),
         .byte_in   (chain_byte[k]),
         .valid_in  (chain_valid[k]),
         .byte_out  (chain_byte[k+1]),
         .valid_out (chain_valid[k+1]),
         .match     (slot_match[k])
      );
   end

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      accept     = req_chan.valid && req_chan.ready;
      is_newline = (req_chan.data_byte == NEWLINE_BYTE);
      line_ends  = is_newline || req_chan.end_of_stream;
      ctl.shift  = accept && !is_newline;
      ctl.clear  = accept && line_ends;

      hit_now  = line_hit_ff || (!is_newline && (cfg.used_len != 5'd0) && (&slot_match));
      selected = ((cfg.used_len == 5'd0) ? 1'b1 : hit_now) ^ cfg.invert_selection;
      emit     = accept && line_ends && selected;

      line_hit_in     = line_hit_ff;
      line_counter_in = line_counter_ff;
      if (accept) begin
         line_hit_in = line_ends ? 1'b0 : hit_now;
         if (req_chan.end_of_stream) begin
            line_counter_in = 32'd1;
         end else if (line_ends && line_counter_ff != '1) begin
            line_counter_in = line_counter_ff + 32'd1;
         end
      end

      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_line_in  = rsp_line_ff;
      rsp_eos_in   = rsp_eos_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_line_in  = line_counter_ff;
         rsp_eos_in   = req_chan.end_of_stream;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff    <= 1'b0;
         line_hit_ff     <= 1'b0;
         line_counter_ff <= 32'd1;
      end else begin
         rsp_valid_ff    <= rsp_valid_in;
         line_hit_ff     <= line_hit_in;
         line_counter_ff <= line_counter_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_line_ff <= rsp_line_in;
      rsp_eos_ff  <= rsp_eos_in;
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.line_number   = rsp_line_ff;
   assign rsp_chan.at_stream_end = rsp_eos_ff;

endmodule

/* tb/line_substring_filter_checker.sv */
// ----------------------------------------------------------------------------
// line_substring_filter_checker
// Watches the byte, result and CSR ports of the line substring filter. It
// keeps its own copy of the line state and settings, predicts which line
// numbers are reported, and compares each result transfer with the oldest
// pending report.
// ----------------------------------------------------------------------------
module line_substring_filter_checker
   import lsf_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   lsf_req_if                    req_mon,
   lsf_rsp_if                    rsp_mon,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data,
   output int                    mismatch_count,
   output int                    results_pending
);

   typedef struct packed {
      logic [31:0] line_number;
      logic        at_stream_end;
   } line_report_type;

   cfg_type         cfg;              // used_len holds the raw written length
   logic [7:0]      recent [PAT_BYTES];
   logic [4:0]      line_fill;
   logic            line_hit;
   logic [31:0]     line_no;
   line_report_type pending_reports [$];
   line_report_type oldest;

   function automatic logic [7:0] lower(input logic [7:0] b);
      if (cfg.fold_case && b >= 8'h41 && b <= 8'h5a) begin
         return b + 8'h20;
      end
      return b;
   endfunction

   function automatic int span();
      return (cfg.used_len > PAT_BYTES) ? PAT_BYTES : int'(cfg.used_len);
   endfunction

   // recent[0] is the newest byte; pattern byte j lines up with slot n-1-j
   function automatic logic tail_matches();
      int n;
      n = span();
      if (n == 0 || line_fill < n) begin
         return 1'b0;
      end
      for (int j = 0; j < n; j++) begin
         if (lower(recent[n-1-j]) != lower(cfg.pattern[j])) begin
            return 1'b0;
         end
      end
      return 1'b1;
   endfunction

   task automatic absorb_byte(input logic [7:0] b, input logic eos);
      logic            ends;
      logic            chosen;
      line_report_type rep;
      int              k;
      ends = 1'b0;
      if (b == NEWLINE_BYTE) begin
         ends = 1'b1;
      end else begin
         for (k = PAT_BYTES - 1; k > 0; k--) begin
            recent[k] = recent[k-1];
         end
         recent[0] = b;
         if (line_fill < PAT_BYTES) begin
            line_fill++;
         end
         if (tail_matches()) begin
            line_hit = 1'b1;
         end
         ends = eos;
      end
      if (ends) begin
         chosen = (span() == 0) ? 1'b1 : line_hit;
         if (cfg.invert_selection) begin
            chosen = !chosen;
         end
         if (chosen) begin
            rep.line_number   = line_no;
            rep.at_stream_end = eos;
            pending_reports.push_back(rep);
         end
         line_fill = '0;
         line_hit  = 1'b0;
         if (line_no != '1) begin
            line_no++;
         end
      end
      if (eos) begin
         line_fill = '0;
         line_hit  = 1'b0;
         line_no   = 32'd1;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         cfg = '0;
         foreach (recent[k]) recent[k] = '0;
         line_fill = '0;
         line_hit  = 1'b0;
         line_no   = 32'd1;
         pending_reports.delete();
         mismatch_count = 0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_PAT_LOW:  cfg.pattern[7:0]      = csr_write_data;
               CSR_PAT_HIGH: cfg.pattern[15:8]     = csr_write_data;
               CSR_PAT_LEN:  cfg.used_len          = csr_write_data[4:0];
               CSR_FOLD:     cfg.fold_case         = csr_write_data[0];
               CSR_INVERT:   cfg.invert_selection  = csr_write_data[0];
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready) begin
            absorb_byte(req_mon.data_byte, req_mon.end_of_stream);
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (pending_reports.size() == 0) begin
               $error("unexpected result transfer: line_number %0d at_stream_end %0b",
                      rsp_mon.line_number, rsp_mon.at_stream_end);
               mismatch_count++;
            end else begin
               oldest = pending_reports.pop_front();
               if (rsp_mon.line_number !== oldest.line_number) begin
                  $error("line_number: expected %0d, got %0d",
                         oldest.line_number, rsp_mon.line_number);
                  mismatch_count++;
               end
               if (rsp_mon.at_stream_end !== oldest.at_stream_end) begin
                  $error("at_stream_end: expected %0b, got %0b",
                         oldest.at_stream_end, rsp_mon.at_stream_end);
                  mismatch_count++;
               end
            end
         end
      end
      results_pending = pending_reports.size();
   end

endmodule

/* tb/line_substring_filter_test.sv */
// ----------------------------------------------------------------------------
// line_substring_filter_test
// Drives byte streams into the line substring filter under a series of
// pattern, case folding and inversion settings. Directed lines hit the
// corner cases, then random streams of lines that carry the pattern, part
// of it or none of it, mixed with raw noise. Both sides idle in bursts.
// ----------------------------------------------------------------------------
module line_substring_filter_test;
   import lsf_pkg::*;

   localparam int RUN_LIMIT   = 300000;
   localparam int PHASES      = 9;
   localparam int PHASE_ITEMS = 56;
   localparam int SETTLE      = 4;

   logic                  clock;
   logic                  reset;
   logic                  csr_write_enable;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_write_data;

   int mismatch_count;
   int results_pending;
   int gap_pct;
   int stall_pct;
   int bytes_sent;
   int cycle_count;

   pattern_type cur_pattern;
   logic [4:0]  cur_len;
   logic        cur_fold;

   // pattern bytes around the case folding range, plus zero and high bytes
   logic [7:0] corner_pat [PAT_BYTES] = '{8'h00, 8'hff, 8'h5a, 8'h40, 8'h5b, 8'h60,
                                          8'h61, 8'h7a, 8'h7b, 8'h80, 8'h7f, 8'h01,
                                          8'h4d, 8'hfe, 8'h71, 8'h30};

   lsf_req_if req_chan ();
   lsf_rsp_if rsp_chan ();

   line_substring_filter dut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   line_substring_filter_checker filter_check (
      .clock            (clock),
      .reset            (reset),
      .req_mon          (req_chan),
      .rsp_mon          (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .mismatch_count   (mismatch_count),
      .results_pending  (results_pending)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < RUN_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("line_substring_filter test failed");
      $finish;
   end

   // result side: ready drops in random bursts
   initial begin
      rsp_chan.ready <= 1'b1;
      forever begin
         @(posedge clock);
         if ($urandom_range(1, 100) <= stall_pct) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
      end
   end

   function automatic int pattern_span();
      return (cur_len > PAT_BYTES) ? PAT_BYTES : int'(cur_len);
   endfunction

   function automatic logic [7:0] vary_case(input logic [7:0] b);
      if (cur_fold && ((b >= 8'h41 && b <= 8'h5a) || (b >= 8'h61 && b <= 8'h7a))
          && $urandom_range(0, 1)) begin
         return b ^ 8'h20;
      end
      return b;
   endfunction

   function automatic logic [7:0] fill_byte();
      logic [7:0] b;
      int         n;
      n = pattern_span();
      case ($urandom_range(0, 4))
         0, 1: b = (n > 0) ? cur_pattern[$urandom_range(0, n - 1)] : 8'h61;
         2:    b = 8'($urandom_range(8'h41, 8'h7a));
         3:    b = 8'($urandom_range(0, 255));
         default: b = ((n > 0) ? cur_pattern[$urandom_range(0, n - 1)] : 8'h40) ^ 8'h20;
      endcase
      if (b == NEWLINE_BYTE) begin
         b = 8'h2e;
      end
      return vary_case(b);
   endfunction

   task automatic send_byte(input logic [7:0] b, input logic eos);
      if ($urandom_range(1, 100) <= gap_pct) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_chan.valid         <= 1'b1;
      req_chan.data_byte     <= b;
      req_chan.end_of_stream <= eos;
      do @(posedge clock); while (!req_chan.ready);
      bytes_sent++;
   endtask

   task automatic send_string(input string s, input logic eos_last);
      for (int i = 0; i < s.len(); i++) begin
         send_byte(s[i], eos_last && (i == s.len() - 1));
      end
   endtask

   // kind: 0 no pattern, 1 whole pattern, 2 pattern missing its last byte
   task automatic send_line(input int kind, input logic last);
      logic [7:0] text [$];
      int         n;
      int         at;
      int         plen;
      logic       eos_on_byte;
      n    = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 6);
      at   = $urandom_range(0, n);
      plen = pattern_span();
      if (kind == 2 && plen > 0) begin
         plen--;
      end
      for (int i = 0; i <= n; i++) begin
         if (kind != 0 && i == at) begin
            for (int j = 0; j < plen; j++) begin
               text.push_back(vary_case(cur_pattern[j]));
            end
         end
         if (i < n) begin
            text.push_back(fill_byte());
         end
      end
      eos_on_byte = last && text.size() > 0 && $urandom_range(0, 1);
      foreach (text[i]) begin
         send_byte(text[i], eos_on_byte && (i == text.size() - 1));
      end
      if (!eos_on_byte) begin
         send_byte(NEWLINE_BYTE, last);
      end
   endtask

   task automatic write_setting(input pattern_type pat, input logic [4:0] len,
                                input logic fold, input logic inv);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_PAT_LOW;
      csr_write_data   <= pat[7:0];
      @(posedge clock);
      csr_index        <= CSR_PAT_HIGH;
      csr_write_data   <= pat[15:8];
      @(posedge clock);
      csr_index        <= CSR_PAT_LEN;
      csr_write_data   <= {59'd0, len};
      @(posedge clock);
      csr_index        <= CSR_FOLD;
      csr_write_data   <= {63'd0, fold};
      @(posedge clock);
      csr_index        <= CSR_INVERT;
      csr_write_data   <= {63'd0, inv};
      @(posedge clock);
      csr_write_enable <= 1'b0;
      cur_pattern = pat;
      cur_len     = len;
      cur_fold    = fold;
   endtask

   // hold the sender until every predicted result has been transferred
   task automatic settle_outputs();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (results_pending != 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   initial begin : stimulus
      pattern_type pat;
      int          start;
      int          nl;
      logic [4:0]  len;

      reset                  <= 1'b1;
      req_chan.valid         <= 1'b0;
      req_chan.data_byte     <= '0;
      req_chan.end_of_stream <= 1'b0;
      csr_write_enable       <= 1'b0;
      csr_index              <= CSR_PAT_LOW;
      csr_write_data         <= '0;
      cur_pattern = '0;
      cur_len     = '0;
      cur_fold    = 1'b0;
      gap_pct     = 20;
      stall_pct   = 20;
      bytes_sent  = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // reset settings: empty pattern, every line reported
      send_string("q\n", 1'b0);
      send_string("\n", 1'b0);
      send_string("z", 1'b1);
      settle_outputs();

      pat = '0;
      pat[0] = 8'h41;
      pat[1] = 8'h62;
      write_setting(pat, 5'd2, 1'b1, 1'b0);
      send_string("xaB\n", 1'b0);
      send_string("a\n", 1'b0);     // shorter than the pattern
      send_string("\n", 1'b1);      // stream ends on newline, no trailing line
      send_string("AB", 1'b1);      // stream ends inside the line
      settle_outputs();

      foreach (corner_pat[k]) pat[k] = corner_pat[k];
      write_setting(pat, 5'd16, 1'b1, 1'b0);
      for (int k = 0; k < PAT_BYTES; k++) begin
         send_byte(vary_case(corner_pat[k]), k == PAT_BYTES - 1);
      end

      for (int ph = 0; ph < PHASES; ph++) begin
         settle_outputs();
         case ($urandom_range(0, 2))
            0: foreach (pat[k]) pat[k] = 8'($urandom_range(0, 255));
            1: foreach (pat[k]) pat[k] = $urandom_range(0, 1) ?
                                         8'($urandom_range(8'h41, 8'h5a)) :
                                         8'($urandom_range(8'h61, 8'h7a));
            default: foreach (pat[k]) pat[k] = 8'h61 + 8'($urandom_range(0, 1));
         endcase
         case (ph)
            0:       len = 5'd0;
            1:       len = 5'd1;
            2:       len = 5'd16;
            3:       len = 5'($urandom_range(17, 31));
            default: len = 5'($urandom_range(2, 15));
         endcase
         write_setting(pat, len, 1'($urandom_range(0, 1)),
                       (ph == 0) ? 1'b1 : 1'($urandom_range(0, 1)));
         if (ph == PHASES - 1) begin
            gap_pct   = 0;
            stall_pct = 0;
         end else begin
            gap_pct   = 15 * $urandom_range(0, 3);
            stall_pct = 15 * $urandom_range(0, 3);
         end
         start = bytes_sent;
         while (bytes_sent - start < PHASE_ITEMS) begin
            if ($urandom_range(0, 9) < 8) begin
               nl = $urandom_range(1, 5);
               for (int l = 0; l < nl; l++) begin
                  send_line($urandom_range(0, 2), l == nl - 1);
               end
            end else begin
               repeat ($urandom_range(10, 20)) begin
                  send_byte(($urandom_range(0, 5) == 0) ? NEWLINE_BYTE :
                            8'($urandom_range(0, 255)),
                            $urandom_range(0, 15) == 0);
               end
            end
         end
      end

      settle_outputs();
      if (mismatch_count == 0) begin
         $display("line_substring_filter test passed");
      end else begin
         $display("line_substring_filter test failed");
      end
      $finish;
   end

endmodule
